### sv/plus_blur_half_downscale_core_macros.svh
// assertion helpers for the checker file
`ifndef PLUS_BLUR_HALF_DOWNSCALE_CORE_MACROS_SVH
`define PLUS_BLUR_HALF_DOWNSCALE_CORE_MACROS_SVH

// clocked check, switched off while reset is asserted
`define PBHD_ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// clocked check that also holds through reset
`define PBHD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

### sv/pbhd_pkg.sv
package pbhd_pkg;

    // pixel word of four 8-bit channels
    localparam int PIX_W = 32;
    typedef logic [PIX_W-1:0] t_pixel;

    // clears the top bit of every byte after the shift
    localparam t_pixel HALF_MASK = 32'h7f7f7f7f;

    // line store lanes: centre row in the low half, upper row in the high half
    localparam int LANE_CENTRE = 0;
    localparam int LANE_UPPER  = 1;
    localparam int NUM_LANES   = 2;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // per-pixel classification made by the front
    typedef struct packed {
        logic odd_row;
        logic emit;
        logic top_zero;
        logic left_zero;
        logic right_zero;
        logic frame_last;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

    // per-byte half-sum, no carry can cross a byte
    function automatic t_pixel byte_avg(input t_pixel a, input t_pixel b);
        return ((a >> 1) & HALF_MASK) + ((b >> 1) & HALF_MASK);
    endfunction

endpackage

### sv/pbhd_ram.sv
module pbhd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 192,
    parameter int LANES = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW   = WIDTH / LANES
) (
    input  logic             i_clk,
    input  logic [LANES-1:0] i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // lane-masked write
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                r_mem[i_waddr][l*LW +: LW] <= i_wdata[l*LW +: LW];
            end
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### sv/pbhd_front.sv
module pbhd_front import pbhd_pkg::*; #(
    parameter int SRC_WIDTH  = 192,
    parameter int SRC_HEIGHT = 64,
    localparam int COL_W     = $clog2(SRC_WIDTH),
    localparam int ROW_W     = $clog2(SRC_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pixel           i_pixel,
    input  logic             i_frame_first,
    input  logic             i_space,
    output logic             o_push,
    output logic [COL_W-1:0] o_col,
    output t_pixel           o_pixel,
    output t_flags           o_flags
);

    localparam int LAST_OUT_ROW = (SRC_HEIGHT / 2) * 2 - 1;
    localparam int LAST_OUT_COL = ((SRC_WIDTH - 1) / 2) * 2;

    logic [COL_W-1:0] r_col, n_col, w_col;
    logic [ROW_W-1:0] r_row, n_row, w_row;
    logic             w_col_end, w_row_end;

    assign o_in_ready = i_space;
    assign o_push     = i_in_valid && i_space;

    // position of this pixel, a frame mark restarts at the origin
    assign w_col     = i_frame_first ? '0 : r_col;
    assign w_row     = i_frame_first ? '0 : r_row;
    assign w_col_end = (w_col == COL_W'(SRC_WIDTH - 1));
    assign w_row_end = (w_row == ROW_W'(SRC_HEIGHT - 1));

    // raster advance with wrap at row and frame end
    always_comb begin
        n_col = w_col + COL_W'(1);
        n_row = w_row;
        if (w_col_end) begin
            n_col = '0;
            n_row = w_row_end ? '0 : w_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // classification handed to the back
    always_comb begin
        o_flags.odd_row    = w_row[0];
        o_flags.emit       = w_row[0] && !w_col[0];
        o_flags.top_zero   = (w_row == ROW_W'(1));
        o_flags.left_zero  = (w_col == '0);
        o_flags.right_zero = w_col_end;
        o_flags.frame_last = (w_row == ROW_W'(LAST_OUT_ROW)) &&
                             (w_col == COL_W'(LAST_OUT_COL));
    end

    assign o_col   = w_col;
    assign o_pixel = i_pixel;

endmodule

### sv/pbhd_queue.sv
module pbhd_queue #(
    parameter int WIDTH = 45,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_avail
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_space = (r_count != CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/pbhd_back.sv
module pbhd_back import pbhd_pkg::*; #(
    parameter int SRC_WIDTH = 192,
    localparam int COL_W    = $clog2(SRC_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  logic [COL_W-1:0] i_col,
    input  t_pixel           i_pixel,
    input  t_flags           i_flags,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pixel           o_out_pixel,
    output logic             o_frame_last
);

    localparam int STORE_W = NUM_LANES * PIX_W;

    logic [NUM_LANES-1:0] w_we;
    logic [COL_W-1:0]     w_raddr_b;
    logic [STORE_W-1:0]   w_rd_a, w_rd_b;

    logic   r_s1_valid, n_s1_valid;
    t_pixel r_s1_pixel;
    t_flags r_s1_flags;
    t_pixel r_left;
    logic   r_out_valid, n_out_valid;
    t_pixel r_out_pixel;
    logic   r_out_last;

    logic   w_s1_move, w_load;
    t_pixel w_mid, w_top, w_left, w_right, w_side, w_result;

    // stage one may take a new pixel once its current one leaves
    assign w_s1_move = r_s1_valid && (!r_s1_flags.emit || !r_out_valid || i_out_ready);
    assign o_pop     = i_avail && (!r_s1_valid || w_s1_move);
    assign w_load    = w_s1_move && r_s1_flags.emit;

    // even rows fill the centre lane, odd rows the upper lane
    always_comb begin
        w_we              = '0;
        w_we[LANE_CENTRE] = o_pop && !i_flags.odd_row;
        w_we[LANE_UPPER]  = o_pop && i_flags.odd_row;
    end

    assign w_raddr_b = i_flags.right_zero ? i_col : i_col + COL_W'(1);

    pbhd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SRC_WIDTH),
        .LANES (NUM_LANES)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (i_col),
        .i_wdata   ({NUM_LANES{i_pixel}}),
        .i_re      (o_pop),
        .i_raddr_a (i_col),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // plus-shaped neighbourhood, borders forced to zero
    always_comb begin
        w_mid    = w_rd_a[LANE_CENTRE*PIX_W +: PIX_W];
        w_top    = r_s1_flags.top_zero ? '0 : w_rd_a[LANE_UPPER*PIX_W +: PIX_W];
        w_right  = r_s1_flags.right_zero ? '0 : w_rd_b[LANE_CENTRE*PIX_W +: PIX_W];
        w_left   = r_s1_flags.left_zero ? '0 : r_left;
        w_side   = byte_avg(byte_avg(w_left, w_right), byte_avg(w_top, r_s1_pixel));
        w_result = byte_avg(w_mid, w_side);
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_pop) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: stage one, left neighbour history, output register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_pixel <= i_pixel;
            r_s1_flags <= i_flags;
        end
        if (w_s1_move && r_s1_flags.odd_row) begin
            r_left <= w_mid;
        end
        if (w_load) begin
            r_out_pixel <= w_result;
            r_out_last  <= r_s1_flags.frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_pixel  = r_out_pixel;
    assign o_frame_last = r_out_last;

endmodule

### sv/plus_blur_half_downscale_core.sv
// path: the bottom neighbour pixel goes via queue and stage one to the output register
// throughput: one source pixel per cycle unless the output stalls, set by a single
// line store pass; centre and right neighbours come on two ports, the left one is held
// reset: synchronous, active low; clears position counters, queue and pipeline valids
// line stores are not cleared; the top border is forced to zero on the first output row
module plus_blur_half_downscale_core import pbhd_pkg::*; #(
    parameter int SRC_WIDTH  = 192,
    parameter int SRC_HEIGHT = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_pixel i_pixel,
    input  logic   i_frame_first,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_pixel o_out_pixel,
    output logic   o_frame_last
);

    localparam int COL_W   = $clog2(SRC_WIDTH);
    localparam int ENTRY_W = COL_W + PIX_W + FLAGS_W;

    logic               w_space, w_push, w_pop, w_avail;
    logic [COL_W-1:0]   w_col;
    t_pixel             w_pixel;
    t_flags             w_flags;
    logic [ENTRY_W-1:0] w_head;
    logic [COL_W-1:0]   w_head_col;
    t_pixel             w_head_pixel;
    t_flags             w_head_flags;

    // position tracking and classification
    pbhd_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_first (i_frame_first),
        .i_space       (w_space),
        .o_push        (w_push),
        .o_col         (w_col),
        .o_pixel       (w_pixel),
        .o_flags       (w_flags)
    );

    // short queue decoupling the two sides
    pbhd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_col, w_pixel, w_flags}),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_avail (w_avail)
    );

    assign w_head_flags = t_flags'(w_head[FLAGS_W-1:0]);
    assign w_head_pixel = w_head[FLAGS_W +: PIX_W];
    assign w_head_col   = w_head[FLAGS_W+PIX_W +: COL_W];

    // line stores and blur arithmetic
    pbhd_back #(
        .SRC_WIDTH (SRC_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (w_avail),
        .i_col        (w_head_col),
        .i_pixel      (w_head_pixel),
        .i_flags      (w_head_flags),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_pixel  (o_out_pixel),
        .o_frame_last (o_frame_last)
    );

endmodule

### sv/pbhd_checker.sv
`include "plus_blur_half_downscale_core_macros.svh"

module pbhd_checker import pbhd_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   o_in_ready,
    input t_pixel i_pixel,
    input logic   i_frame_first,
    input logic   o_out_valid,
    input logic   i_out_ready,
    input t_pixel o_out_pixel,
    input logic   o_frame_last
);

    // a stalled result stays offered and unchanged
    `PBHD_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_pixel) && $stable(o_frame_last))

    // reset empties the output register
    `PBHD_ASSERT_ALWAYS(a_reset_out_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // reset leaves the queue empty, so input is taken at once
    `PBHD_ASSERT_ALWAYS(a_reset_in_ready, i_clk, !i_rst_n |=> o_in_ready)

endmodule

bind plus_blur_half_downscale_core pbhd_checker u_checker (.*);
